// File: hw/rtl/sks_pkg.sv
package sks_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int TAG_WIDTH   = 16;
   localparam int IDX_WIDTH   = $clog2(MAX_RECORDS);
   localparam int CNT_WIDTH   = $clog2(MAX_RECORDS + 1);

   // input beat
   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] record_key;
      logic [TAG_WIDTH-1:0]        record_tag;
      logic                        set_last;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] sorted_key;
      logic [TAG_WIDTH-1:0]        sorted_tag;
      logic                        out_last;
      logic                        overflowed;
   } rsp_type;

   // one record held in a cell
   typedef struct packed {
      logic signed [KEY_WIDTH-1:0] key;
      logic [TAG_WIDTH-1:0]        tag;
   } rec_type;

   // controller to cell row
   typedef struct packed {
      logic                 load;
      logic                 sort;
      logic                 shift;
      logic                 phase_odd;
      logic                 descending;
      logic [CNT_WIDTH-1:0] count;
   } ctrl_type;

   // controller to result port
   typedef struct packed {
      logic emit_valid;
      logic emit_last;
      logic overflowed;
   } stat_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // strict ordering: a must leave before b (equal keys never swap)
   function automatic logic goes_before(input logic signed [KEY_WIDTH-1:0] a,
                                        input logic signed [KEY_WIDTH-1:0] b,
                                        input logic descending);
      goes_before = descending ? (a > b) : (a < b);
   endfunction

endpackage

// File: hw/rtl/sks_cell.sv
module sks_cell (
   input  logic                          clock,
   input  sks_pkg::ctrl_type             ctrl,
   input  logic [sks_pkg::IDX_WIDTH-1:0] cell_index,
   input  sks_pkg::rec_type              load_rec,
   input  sks_pkg::rec_type              left_rec,
   input  logic                          left_swap,
   input  sks_pkg::rec_type              right_rec,
   output sks_pkg::rec_type              rec_out,
   output logic                          swap_out
);
   import sks_pkg::*;

   rec_type              rec_ff;
   rec_type              rec_in;
   logic                 low_active;
   logic [CNT_WIDTH-1:0] index_wide;

   assign index_wide = CNT_WIDTH'(cell_index);

   // this cell is the lower half of a compare pair in the current phase
   assign low_active = ctrl.sort && (cell_index[0] == ctrl.phase_odd)
                       && ((index_wide + CNT_WIDTH'(1)) < ctrl.count);
   assign swap_out   = low_active && goes_before(right_rec.key, rec_ff.key, ctrl.descending);

   // next content: load slot, pair exchange, or drain towards cell 0
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.load && (index_wide == ctrl.count)) begin
         rec_in = load_rec;
      end else if (swap_out || ctrl.shift) begin
         rec_in = right_rec;
      end else if (left_swap) begin
         rec_in = left_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

// File: hw/rtl/sks_ctrl.sv
module sks_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  logic              csr_valid,
   input  logic              csr_data,
   output logic              csr_ready,
   output sks_pkg::ctrl_type ctrl,
   output sks_pkg::stat_type stat
);
   import sks_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] fill_ff, fill_in;
   logic [CNT_WIDTH-1:0] phase_ff, phase_in;
   logic [CNT_WIDTH-1:0] rem_ff, rem_in;
   logic                 ovf_ff, ovf_in;
   logic                 cfg_ff, cfg_in;
   logic                 desc_ff, desc_in;

   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;

   // sequencer: load, transposition passes, drain
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      rem_in   = rem_ff;
      ovf_in   = ovf_ff;
      desc_in  = desc_ff;
      cfg_in   = csr_valid ? csr_data : cfg_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (fill_ff < CNT_WIDTH'(MAX_RECORDS)) begin
                  fill_in = fill_ff + CNT_WIDTH'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  desc_in  = cfg_ff;
                  phase_in = '0;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            phase_in = phase_ff + CNT_WIDTH'(1);
            if (phase_ff == (fill_ff - CNT_WIDTH'(1))) begin
               rem_in   = fill_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rem_in = rem_ff - CNT_WIDTH'(1);
               if (rem_ff == CNT_WIDTH'(1)) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         phase_ff <= '0;
         rem_ff   <= '0;
         ovf_ff   <= 1'b0;
         cfg_ff   <= 1'b0;
         desc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         ovf_ff   <= ovf_in;
         cfg_ff   <= cfg_in;
         desc_ff  <= desc_in;
      end
   end

   // cell row control
   assign ctrl.load       = (state_ff == ST_LOAD) && req_valid;
   assign ctrl.sort       = (state_ff == ST_SORT);
   assign ctrl.shift      = (state_ff == ST_EMIT) && rsp_ready;
   assign ctrl.phase_odd  = phase_ff[0];
   assign ctrl.descending = desc_ff;
   assign ctrl.count      = fill_ff;

   assign stat.emit_valid = (state_ff == ST_EMIT);
   assign stat.emit_last  = (rem_ff == CNT_WIDTH'(1));
   assign stat.overflowed = ovf_ff;

endmodule

// File: hw/rtl/stable_key_sorter_core.sv
// Stable key sorter.
// req channel: one record per beat (key, tag, set_last); set_last closes the set.
// While loading, req_ready is high and one beat is taken every cycle that
// req_valid is high. Records beyond 64 are dropped and every result of that
// set carries overflowed. After the closing beat the row of 64 cells runs n
// odd-even transposition passes, one per cycle (n = records held), then
// drains the set on the rsp channel from cell 0, lowest key first (highest
// when descending), one beat per cycle while rsp_ready is high; out_last
// marks the final beat. rsp_valid rises once the last pass is done, and
// req_ready returns once the final result beat has been taken.
// req_ready is low while sorting and draining.
// csr channel: one bit, sort_descending, always ready; it is sampled when the
// closing beat is taken.
// A stalled receiver holds rsp_valid with the beat unchanged; the row simply
// waits. Synchronous reset empties the set, clears the overflow flag and the
// direction bit; cell contents are not cleared.
module stable_key_sorter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sks_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import sks_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   rec_type  load_rec;
   rec_type  cell_rec  [MAX_RECORDS];
   logic     cell_swap [MAX_RECORDS];

   sks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.set_last),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   assign load_rec.key = req_data.record_key;
   assign load_rec.tag = req_data.record_tag;

   // row of cells, cell 0 faces the result port
   for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;
      logic    left_swap;

      if (g == 0) begin : g_first
         assign left_rec  = '0;
         assign left_swap = 1'b0;
      end else begin : g_mid
         assign left_rec  = cell_rec[g-1];
         assign left_swap = cell_swap[g-1];
      end

      if (g == MAX_RECORDS - 1) begin : g_end
         assign right_rec = '0;
      end else begin : g_next
         assign right_rec = cell_rec[g+1];
      end

      sks_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_WIDTH'(g)),
         .load_rec   (load_rec),
         .left_rec   (left_rec),
         .left_swap  (left_swap),
         .right_rec  (right_rec),
         .rec_out    (cell_rec[g]),
         .swap_out   (cell_swap[g])
      );
   end

   // result beat straight from the head cell
   assign rsp_valid           = stat.emit_valid;
   assign rsp_data.sorted_key = cell_rec[0].key;
   assign rsp_data.sorted_tag = cell_rec[0].tag;
   assign rsp_data.out_last   = stat.emit_last;
   assign rsp_data.overflowed = stat.overflowed;

endmodule

// File: hw/rtl/sks_checker.sv
module sks_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sks_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sks_pkg::rsp_type rsp_data
);
   import sks_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // loading and draining never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while results pending");

   // closing beat stops intake
   a_close_stops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.set_last |=> !req_ready)
      else $error("input still taken after set closed");

   // final result ends the burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.out_last |=> !rsp_valid && req_ready)
      else $error("results continue after last beat");

endmodule

bind stable_key_sorter_core sks_checker u_sks_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: verif/tb_stable_key_sorter_core.sv
module tb_stable_key_sorter_core;

   import sks_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 6;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 55;
   // time allowed for a full set to sort and drain
   localparam int DRAIN_CYCLES = 2 * MAX_RECORDS + 8;
   localparam int CYCLE_LIMIT  = 200000;

   // idling styles per phase
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Scoreboard: mirrors the set being loaded and keeps the sorted beats
   // still owed by the block.
   class sorter_scoreboard;
      req_type loaded_q[$];
      rsp_type expected_q[$];
      bit      descending;
      bit      dropped;
      int      fails;
      int      records_seen;
      int      sets_closed;
      int      overflow_sets;
      int      descending_sets;
      int      results_checked;

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         fails++;
      endtask

      // accepted input beat; the closing beat sorts the set (stable insertion)
      function void note_record(input req_type rec);
         req_type                     sorted[$];
         req_type                     cur;
         rsp_type                     exp;
         logic signed [KEY_WIDTH-1:0] ck;
         logic signed [KEY_WIDTH-1:0] pk;
         int                          j;
         records_seen++;
         if (loaded_q.size() < MAX_RECORDS)
            loaded_q.push_back(rec);
         else
            dropped = 1'b1;
         if (!rec.set_last)
            return;
         sorted = loaded_q;
         for (int i = 1; i < sorted.size(); i++) begin
            cur = sorted[i];
            ck  = cur.record_key;
            j   = i;
            while (j > 0) begin
               pk = sorted[j-1].record_key;
               // strict compare keeps equal keys in load order
               if (descending ? (ck > pk) : (ck < pk)) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end else begin
                  break;
               end
            end
            sorted[j] = cur;
         end
         foreach (sorted[i]) begin
            exp.sorted_key = sorted[i].record_key;
            exp.sorted_tag = sorted[i].record_tag;
            exp.out_last   = (i == sorted.size() - 1);
            exp.overflowed = dropped;
            expected_q.push_back(exp);
         end
         sets_closed++;
         if (dropped)
            overflow_sets++;
         if (descending)
            descending_sets++;
         loaded_q.delete();
         dropped = 1'b0;
      endfunction

      // accepted result beat against the oldest expectation
      task check_result(input rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing expected: key %0d tag %h",
                             got.sorted_key, got.sorted_tag));
            return;
         end
         exp = expected_q.pop_front();
         results_checked++;
         if (got.sorted_key !== exp.sorted_key)
            report($sformatf("result %0d sorted_key %0d, expected %0d",
                             results_checked, got.sorted_key, exp.sorted_key));
         if (got.sorted_tag !== exp.sorted_tag)
            report($sformatf("result %0d sorted_tag %h, expected %h",
                             results_checked, got.sorted_tag, exp.sorted_tag));
         if (got.out_last !== exp.out_last)
            report($sformatf("result %0d out_last %b, expected %b",
                             results_checked, got.out_last, exp.out_last));
         if (got.overflowed !== exp.overflowed)
            report($sformatf("result %0d overflowed %b, expected %b",
                             results_checked, got.overflowed, exp.overflowed));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   sorter_scoreboard sb;
   int               cycle_count;
   int               send_idle_pct;
   int               stall_pct;

   idle_mode_type phase_mode[NUM_PHASES] =
      '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
   bit phase_descending[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

   stable_key_sorter_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watch both channels; values read here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_record(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[stable_key_sorter_core] ERROR");
         $finish;
      end
   end

   // one record beat; valid stays up until the block takes it
   task automatic send_record(input logic signed [KEY_WIDTH-1:0] key,
                              input logic [TAG_WIDTH-1:0] tag, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{record_key: key, record_tag: tag, set_last: last};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // hold the sender off until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_direction(input bit desc);
      csr_valid <= 1'b1;
      csr_data  <= desc;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid      <= 1'b0;
      sb.descending  = desc;
   endtask

   // single record, key extremes with repeats, and a run of equal keys
   task automatic send_directed_sets();
      send_record(0, 16'h1234, 1'b1);
      send_record(32'sh7fff_ffff, 16'hffff, 1'b0);
      send_record(32'sh8000_0000, 16'h0000, 1'b0);
      send_record(-1, 16'h00a1, 1'b0);
      send_record(0, 16'h00a2, 1'b0);
      send_record(1, 16'h00a3, 1'b0);
      send_record(32'sh8000_0000, 16'h00a4, 1'b0);
      send_record(32'sh7fff_ffff, 16'h00a5, 1'b1);
      for (int i = 0; i < 4; i++)
         send_record(7, TAG_WIDTH'(16'h0100 + i), (i == 3));
   endtask

   // about a third tiny keys and a tenth extremes so that ties (and so stability) show up often
   function automatic logic signed [KEY_WIDTH-1:0] pick_key();
      int unsigned sel;
      int          v;
      sel = $urandom_range(99);
      if (sel < 35) begin
         v = $urandom_range(8);
         return v - 4;
      end
      if (sel < 45) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_random_set(input int count);
      for (int k = 0; k < count; k++)
         send_record(pick_key(), TAG_WIDTH'($urandom_range(16'hffff)), (k == count - 1));
   endtask

   initial begin
      int set_size;
      int phase_items;
      int sel;

      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      cycle_count   = 0;
      sb            = new();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         // direction changes only once the block has fully drained
         if (p > 0) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clock);
            write_direction(phase_descending[p]);
         end
         case (phase_mode[p])
            IDLE_SENDER:   begin send_idle_pct = 51; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 51; end
            IDLE_BOTH:     begin send_idle_pct = 35; stall_pct = 35; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
         endcase

         if (p < 2)
            send_directed_sets();
         if (p == 0)
            wait_drained();

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            sel = $urandom_range(29);
            if (sel == 0)
               set_size = $urandom_range(MAX_RECORDS - 4, MAX_RECORDS + 4);
            else if (sel < 6)
               set_size = $urandom_range(11, 20);
            else
               set_size = $urandom_range(1, 10);
            // one exactly full set, and one that overflows and drops its closer
            if (p == 2 && phase_items == 0)
               set_size = MAX_RECORDS;
            if (p == 4 && phase_items == 0)
               set_size = MAX_RECORDS + 3;
            send_random_set(set_size);
            phase_items += set_size;
            if ($urandom_range(7) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d result beats never arrived", sb.expected_q.size()));

      $display("covered %0d record beats in %0d sets (%0d descending, %0d overflowed)",
               sb.records_seen, sb.sets_closed, sb.descending_sets, sb.overflow_sets);
      $display("checked %0d result beats, %0d mismatches", sb.results_checked, sb.fails);
      if (sb.fails == 0)
         $display("[stable_key_sorter_core] OK");
      else
         $display("[stable_key_sorter_core] ERROR");
      $finish;
   end

endmodule
